/* rtl/apra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apra_pkg
// Shared constants, codes and helpers for the adjacent-pair resource arbiter.
// ----------------------------------------------------------------------------
package apra_pkg;

  // sizes
  localparam int MAX_SEATS   = 16;
  localparam int QUEUE_DEPTH = 16;
  localparam int GRANT_CAP   = 8;

  // field and counter widths
  localparam int SEAT_W   = $clog2(MAX_SEATS);
  localparam int NSEATS_W = 5;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 16;
  localparam int QADDR_W  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int GIDX_W   = $clog2(GRANT_CAP);
  localparam int GCNT_W   = $clog2(GRANT_CAP + 1);

  localparam logic [NSEATS_W-1:0] NSEATS_RESET = NSEATS_W'(5);
  localparam logic [NSEATS_W-1:0] NSEATS_MIN   = NSEATS_W'(2);
  localparam logic [NSEATS_W-1:0] NSEATS_MAX   = NSEATS_W'(MAX_SEATS);

  // command codes
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_SEAT = 2'd2;

  // right-hand resource of a seat, wrapping to resource 0
  function automatic logic [SEAT_W-1:0] right_of(input logic [SEAT_W-1:0] s,
                                                 input logic [NSEATS_W-1:0] n);
    logic [NSEATS_W-1:0] nxt;
    nxt = NSEATS_W'(s) + NSEATS_W'(1);
    right_of = (nxt >= n) ? '0 : nxt[SEAT_W-1:0];
  endfunction

endpackage

/* rtl/apra_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apra_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module apra_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/adjacent_pair_resource_arbiter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adjacent_pair_resource_arbiter_top
// Ring arbiter: each seat takes its own and its right-hand resource. Waiters
// sit in a FIFO in RAM; every accepted request or release rescans the queue
// oldest first: ST_SCAN0 starts the scan, ST_SCAN handles one queued waiter
// per step, then ST_EMIT sends the beats; a dropped item skips to ST_EMIT.
// One item at a time: the next is taken only after the last beat, and the
// scan length is set by the single-read-port queue scan.
// Reset: all resources free, queue empty, 5 seats; the queue RAM is not
// cleared, entries at or above the count are never used.
// ----------------------------------------------------------------------------
module adjacent_pair_resource_arbiter_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [apra_pkg::NSEATS_W-1:0]   cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            cmd,
  input  logic [apra_pkg::SEAT_W-1:0]     seat_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            grant_valid,
  output logic [apra_pkg::SEAT_W-1:0]     granted_seat,
  output logic                            last,
  output logic [apra_pkg::STATUS_W-1:0]   status,
  output logic [apra_pkg::FREE_W-1:0]     free_map
);
  import apra_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN0 = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]           state;
  logic [NSEATS_W-1:0]  number_of_seats;
  logic [MAX_SEATS-1:0] resource_free;
  logic [QCNT_W-1:0]    queue_count;
  logic [QCNT_W-1:0]    kept;
  logic [QADDR_W-1:0]   proc_idx;
  logic [GCNT_W-1:0]    ng;
  logic [GIDX_W-1:0]    emit_idx;
  logic [STATUS_W-1:0]  st_reg;
  logic [SEAT_W-1:0]    grant_buf [GRANT_CAP];

  logic [NSEATS_W-1:0]  n_sat;
  logic                 accept;
  logic                 seat_bad;
  logic                 q_full;
  logic [SEAT_W-1:0]    rel_right;
  logic [SEAT_W-1:0]    s_rd;
  logic [SEAT_W-1:0]    s_right;
  logic                 take;
  logic                 more;
  logic                 last_beat;
  logic                 out_fire;

  logic                 ram_we;
  logic [QADDR_W-1:0]   ram_waddr;
  logic [SEAT_W-1:0]    ram_wdata;
  logic [QADDR_W-1:0]   ram_raddr;

  // wait queue storage
  apra_ram #(
    .WIDTH (SEAT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (s_rd)
  );

  // seat count saturated into its legal range
  always_comb begin
    if (number_of_seats < NSEATS_MIN) begin
      n_sat = NSEATS_MIN;
    end else if (number_of_seats > NSEATS_MAX) begin
      n_sat = NSEATS_MAX;
    end else begin
      n_sat = number_of_seats;
    end
  end

  // input checks
  assign in_ready  = (state == ST_IDLE) && !rst;
  assign accept    = in_valid && in_ready;
  assign seat_bad  = (NSEATS_W'(seat_id) >= n_sat);
  assign q_full    = (cmd == CMD_REQUEST) && (queue_count == QCNT_W'(QUEUE_DEPTH));
  assign rel_right = right_of(seat_id, n_sat);

  // scan decision on the waiter just read
  assign s_right = right_of(s_rd, n_sat);
  assign take    = (state == ST_SCAN) && (ng < GCNT_W'(GRANT_CAP))
                   && (NSEATS_W'(s_rd) < n_sat)
                   && resource_free[s_rd] && resource_free[s_right];
  assign more    = (QCNT_W'(proc_idx) + QCNT_W'(1)) < queue_count;

  // ram port control: append on request, compact kept waiters during scan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = queue_count[QADDR_W-1:0];
    ram_wdata = seat_id;
    ram_raddr = '0;
    case (state)
      ST_IDLE: begin
        ram_we = accept && !seat_bad && !q_full && (cmd == CMD_REQUEST);
      end
      ST_SCAN: begin
        ram_we    = !take;
        ram_waddr = kept[QADDR_W-1:0];
        ram_wdata = s_rd;
        ram_raddr = proc_idx + QADDR_W'(1);
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  // result beat
  assign out_valid    = (state == ST_EMIT);
  assign out_fire     = out_valid && out_ready;
  assign grant_valid  = (ng != '0);
  assign granted_seat = grant_valid ? grant_buf[emit_idx] : '0;
  assign last_beat    = !grant_valid || ((GCNT_W'(emit_idx) + GCNT_W'(1)) == ng);
  assign last         = last_beat;
  assign status       = st_reg;
  assign free_map     = FREE_W'(resource_free);

  // grant buffer (payload, no reset)
  always_ff @(posedge clk) begin
    if (take) begin
      grant_buf[ng[GIDX_W-1:0]] <= s_rd;
    end
  end

  // control and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      number_of_seats <= NSEATS_RESET;
      resource_free   <= '1;
      queue_count     <= '0;
      kept            <= '0;
      proc_idx        <= '0;
      ng              <= '0;
      emit_idx        <= '0;
      st_reg          <= STATUS_OK;
    end else begin
      if (cfg_wr_en) begin
        number_of_seats <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ng       <= '0;
            emit_idx <= '0;
            kept     <= '0;
            proc_idx <= '0;
            if (seat_bad) begin
              st_reg <= STATUS_BAD_SEAT;
              state  <= ST_EMIT;
            end else if (q_full) begin
              st_reg <= STATUS_FULL;
              state  <= ST_EMIT;
            end else begin
              st_reg <= STATUS_OK;
              state  <= ST_SCAN0;
              if (cmd == CMD_REQUEST) begin
                queue_count <= queue_count + QCNT_W'(1);
              end else begin
                resource_free <= resource_free | (MAX_SEATS'(1) << seat_id)
                                 | (MAX_SEATS'(1) << rel_right);
              end
            end
          end
        end
        ST_SCAN0: begin
          // entry 0 is being read; skip the scan on an empty queue
          state <= (queue_count == '0) ? ST_EMIT : ST_SCAN;
        end
        ST_SCAN: begin
          if (take) begin
            resource_free <= resource_free & ~((MAX_SEATS'(1) << s_rd)
                                               | (MAX_SEATS'(1) << s_right));
            ng            <= ng + GCNT_W'(1);
          end else begin
            kept <= kept + QCNT_W'(1);
          end
          if (more) begin
            proc_idx <= proc_idx + QADDR_W'(1);
          end else begin
            queue_count <= take ? kept : kept + QCNT_W'(1);
            state       <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_fire) begin
            if (last_beat) begin
              state <= ST_IDLE;
            end else begin
              emit_idx <= emit_idx + GIDX_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // queue occupancy stays within the ram
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // grants per event stay within the cap
  a_grant_cap: assert property (@(posedge clk) disable iff (rst)
    ng <= GCNT_W'(GRANT_CAP))
    else $error("grant count beyond cap");

  // no new item while results are pending
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  // a granted seat holds its own resource
  a_grant_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && grant_valid) |-> !resource_free[granted_seat])
    else $error("granted seat resource still free");
`endif

endmodule
